### design/scac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scac_pkg
// Shared types, widths and constants of the census/AD stereo cost block.
// ----------------------------------------------------------------------------
package scac_pkg;

	localparam int GRAY_W   = 12;
	localparam int CENSUS_W = 8;
	localparam int COST_W   = 13;
	localparam int TRUNC_W  = 12;
	localparam int SHIFT_W  = 6;
	localparam int TERM_W   = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [TRUNC_W-1:0] TRUNC_RESET = 12'd192;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd0;

	// Largest cost: full gray cap plus the census term for eight differing bits.
	localparam logic [COST_W-1:0] COST_MAX = 13'd4121;

	typedef enum logic {
		REG_TRUNCATION = 1'b0,
		REG_SHIFT      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [TRUNC_W-1:0] truncation;
		logic [SHIFT_W-1:0] shift;
	} cfg_t;

	function automatic logic [3:0] popcount8(input logic [CENSUS_W-1:0] v);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < CENSUS_W; k++) begin
			n = n + 4'(v[k]);
		end
		return n;
	endfunction

	// Hamming distance over five in Q.4, rounded to nearest.
	function automatic logic [TERM_W-1:0] census_term(input logic [3:0] p);
		logic [TERM_W-1:0] t;
		case (p)
			4'd0: t = 5'd0;
			4'd1: t = 5'd3;
			4'd2: t = 5'd6;
			4'd3: t = 5'd10;
			4'd4: t = 5'd13;
			4'd5: t = 5'd16;
			4'd6: t = 5'd19;
			4'd7: t = 5'd22;
			4'd8: t = 5'd26;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

### design/scac_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scac_cfg
// APB register file holding the truncation cap and the disparity.
// ----------------------------------------------------------------------------
module scac_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [scac_pkg::APB_AW-1:0]  paddr,
	input  wire logic [scac_pkg::APB_DW-1:0]  pwdata,
	output logic      [scac_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	output scac_pkg::cfg_t                    cfg
);
	import scac_pkg::*;

	logic [TRUNC_W-1:0] truncation_q;
	logic [SHIFT_W-1:0] shift_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	// Registers are word aligned; the low address bits are ignored.
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			truncation_q <= TRUNC_RESET;
			shift_q      <= SHIFT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TRUNCATION: truncation_q <= pwdata[TRUNC_W-1:0];
				REG_SHIFT:      shift_q      <= pwdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TRUNCATION: prdata = APB_DW'(truncation_q);
			REG_SHIFT:      prdata = APB_DW'(shift_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.truncation = truncation_q;
	assign cfg.shift      = shift_q;

endmodule
`default_nettype wire

### design/stereo_census_ad_cost.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_census_ad_cost
// Census plus absolute-difference matching cost for one disparity.
// ----------------------------------------------------------------------------
// Usage: left/right pixel pairs enter in raster order on the pix channel
// (pix_valid/pix_ready), with row_start marking column zero of each row. One
// cost leaves per pair on the cost channel (cost_valid/cost_ready), in order.
// The right pixels are kept in a single-port-write, one-read synchronous RAM
// of MAX_DISPARITY entries; the left pixel at column c meets the right pixel
// at column max(c - shift, 0), where the row's first right pixel is held in
// a register.
// After the input transfer the cost passes through one register for the RAM
// read and one for the output. One pair is taken every cycle while the
// receiver keeps up; the RAM does one write and one read per transfer, and a
// zero disparity is served by bypassing the pixel being written.
// Reset clears the pointers, the column count, the held first pixel and the
// output valid; the first pair after reset starts a row. Configuration is
// reset to a cap of 12.0 and a disparity of zero. When the receiver stalls,
// the output register and the RAM stage hold, and pix_ready drops once both
// are full.
// ----------------------------------------------------------------------------
module stereo_census_ad_cost #(
	parameter int MAX_DISPARITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [scac_pkg::APB_AW-1:0]   paddr,
	input  wire logic [scac_pkg::APB_DW-1:0]   pwdata,
	output logic      [scac_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          pix_valid,
	output logic                               pix_ready,
	input  wire logic [scac_pkg::GRAY_W-1:0]   gray_left,
	input  wire logic [scac_pkg::GRAY_W-1:0]   gray_right,
	input  wire logic [scac_pkg::CENSUS_W-1:0] census_left,
	input  wire logic [scac_pkg::CENSUS_W-1:0] census_right,
	input  wire logic                          row_start,
	output logic                               cost_valid,
	input  wire logic                          cost_ready,
	output logic      [scac_pkg::COST_W-1:0]   cost
);
	import scac_pkg::*;

	localparam int PTR_W = $clog2(MAX_DISPARITY);
	localparam int CNT_W = $clog2(MAX_DISPARITY + 1);
	localparam int LIM_W = (PTR_W > SHIFT_W) ? PTR_W : SHIFT_W;
	localparam int ENT_W = GRAY_W + CENSUS_W;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DISPARITY - 1);
	localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(MAX_DISPARITY - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DISPARITY);
	localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(MAX_DISPARITY - 1);

	cfg_t cfg;

	scac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Control state.
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  col_cnt_q;
	logic [ENT_W-1:0]  first_q;
	logic              valid_s1;
	logic              cost_valid_q;

	// Payload.
	logic [ENT_W-1:0]    mem [MAX_DISPARITY];
	logic [ENT_W-1:0]    rd_data_s1;
	logic [ENT_W-1:0]    alt_s1;
	logic                use_mem_s1;
	logic [GRAY_W-1:0]   gray_left_s1;
	logic [CENSUS_W-1:0] census_left_s1;
	logic [COST_W-1:0]   cost_q;

	// Input side.
	logic                accept;
	logic                out_free;
	logic                s1_adv;
	logic [LIM_W-1:0]    shift_ext;
	logic [PTR_W-1:0]    shift_eff;
	logic [CNT_W-1:0]    col;
	logic                col_past;
	logic [ENT_W-1:0]    right_ent;
	logic [ENT_W-1:0]    first_next;
	logic [PTR_W:0]      rd_wrap;
	logic [PTR_W-1:0]    rd_addr;

	// Cost side.
	logic [ENT_W-1:0]    matched;
	logic [GRAY_W-1:0]   match_gray;
	logic [CENSUS_W-1:0] match_census;
	logic [GRAY_W-1:0]   abs_diff;
	logic [GRAY_W-1:0]   cap_diff;
	logic [COST_W-1:0]   cost_next;

	assign out_free  = !cost_valid_q || cost_ready;
	assign s1_adv    = valid_s1 && out_free;
	assign pix_ready = !valid_s1 || out_free;
	assign accept    = pix_valid && pix_ready;

	assign shift_ext  = LIM_W'(cfg.shift);
	assign shift_eff  = (shift_ext > LIM_MAX) ? PTR_LAST : shift_ext[PTR_W-1:0];
	assign col        = row_start ? '0 : col_cnt_q;
	assign col_past   = col > CNT_W'(shift_eff);
	assign right_ent  = {gray_right, census_right};
	assign first_next = (col == '0) ? right_ent : first_q;

	// Entry written shift_eff transfers ago, wrapping modulo the depth.
	assign rd_wrap = {1'b0, wr_ptr_q} + (PTR_W + 1)'(MAX_DISPARITY) - {1'b0, shift_eff};
	assign rd_addr = (wr_ptr_q >= shift_eff) ? (wr_ptr_q - shift_eff) : rd_wrap[PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			col_cnt_q    <= '0;
			first_q      <= '0;
			valid_s1     <= 1'b0;
			cost_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				wr_ptr_q  <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				col_cnt_q <= (col >= CNT_TOP) ? CNT_MAX : col + 1'b1;
				first_q   <= first_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				cost_valid_q <= 1'b1;
			end else if (cost_ready) begin
				cost_valid_q <= 1'b0;
			end
		end
	end

	// Delay line RAM. A zero disparity would read the entry being written, so
	// that case takes the incoming pixel from the bypass path instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wr_ptr_q] <= right_ent;
			rd_data_s1    <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_mem_s1     <= col_past && (shift_eff != '0);
			alt_s1         <= col_past ? right_ent : first_next;
			gray_left_s1   <= gray_left;
			census_left_s1 <= census_left;
		end
	end

	assign matched      = use_mem_s1 ? rd_data_s1 : alt_s1;
	assign match_gray   = matched[ENT_W-1:CENSUS_W];
	assign match_census = matched[CENSUS_W-1:0];
	assign abs_diff     = (gray_left_s1 >= match_gray) ? (gray_left_s1 - match_gray)
	                                                   : (match_gray - gray_left_s1);
	assign cap_diff     = (abs_diff > cfg.truncation) ? cfg.truncation : abs_diff;
	assign cost_next    = COST_W'(cap_diff)
	                    + COST_W'(census_term(popcount8(census_left_s1 ^ match_census)));

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cost_q <= cost_next;
		end
	end

	assign cost_valid = cost_valid_q;
	assign cost       = cost_q;

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= PTR_LAST)
		else $error("delay line write pointer out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_cnt_q <= CNT_MAX)
		else $error("column count beyond saturation");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!valid_s1 || out_free))
		else $error("transfer accepted while RAM stage cannot move");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transfer did not reach RAM stage");

	a_cost_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid_q |-> (cost_q <= COST_MAX))
		else $error("cost above its largest possible value");
`endif

endmodule
`default_nettype wire
